// File: src/ecpm_pkg.sv
`timescale 1ns / 1ps

package ecpm_pkg;

    localparam int COUNT_W  = 32;
    localparam int NS_W     = 48;
    localparam int CYC_W    = 64;
    localparam int PERF_W   = 8;
    localparam int EXP_W    = 5;
    localparam int UNIT_W   = 10;
    localparam int ACC_W    = 52;
    localparam int MPLIER_W = 20;
    localparam int DIV_CNT_W = 6;
    localparam int PKG_MW_W  = 19;
    localparam int DRAM_MW_W = 16;
    localparam int CORE_MW_W = 19;
    localparam int CLS_CNT_W = 6;
    localparam int CARRY_W   = 10;

    localparam logic [UNIT_W-1:0]    MJ_PER_J      = 10'd1000;
    localparam logic [MPLIER_W-1:0]  NS_SCALE      = 20'd1000000;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST      = 6'd51;
    localparam logic [ACC_W-1:0]     PKG_MAX_MW    = 52'd300000;
    localparam logic [ACC_W-1:0]     DRAM_MAX_MW   = 52'd50000;
    localparam logic [ACC_W-1:0]     CORE_MAX_MW   = 52'd280000;
    localparam logic [PERF_W-1:0]    PERF_COMPUTE  = 8'd200;
    localparam logic [PERF_W-1:0]    PERF_MIXED    = 8'd100;
    localparam logic [CLS_CNT_W-1:0] CLS_CNT_LAST  = 6'd63;

    localparam logic signed [CARRY_W-1:0] ACTIVE_WEIGHT  = 10'sd100;
    localparam logic signed [CARRY_W-1:0] COMPUTE_WEIGHT = 10'sd86;
    localparam logic signed [CARRY_W-1:0] MEMORY_WEIGHT  = 10'sd40;

    typedef enum logic [1:0] {
        CLS_IDLE,
        CLS_COMPUTE,
        CLS_MEMORY,
        CLS_MIXED
    } class_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic   done;
        class_t cls;
    } cls_status_t;

endpackage

// File: src/ecpm_classify.sv
`timescale 1ns / 1ps

module ecpm_classify (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic [ecpm_pkg::CYC_W-1:0]        active_cycles,
    input  logic [ecpm_pkg::CYC_W-1:0]        reference_cycles,
    input  logic                              hint_valid,
    input  logic [ecpm_pkg::PERF_W-1:0]       hint_perf,
    output ecpm_pkg::cls_status_t             status
);

    logic [ecpm_pkg::CYC_W-1:0]          ap_reg, ap_next;
    logic [ecpm_pkg::CYC_W-1:0]          mp_reg, mp_next;
    logic signed [ecpm_pkg::CARRY_W-1:0] c86_reg, c86_next;
    logic signed [ecpm_pkg::CARRY_W-1:0] c40_reg, c40_next;
    logic signed [ecpm_pkg::CARRY_W-1:0] s86, s40, a_term;
    logic [ecpm_pkg::CLS_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                                busy_reg, busy_next;
    logic                                nz_reg, nz_next;
    logic                                hv_reg, hv_next;
    logic [ecpm_pkg::PERF_W-1:0]         perf_reg, perf_next;
    ecpm_pkg::class_t                    cls;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ap_reg   <= ap_next;
        mp_reg   <= mp_next;
        c86_reg  <= c86_next;
        c40_reg  <= c40_next;
        nz_reg   <= nz_next;
        hv_reg   <= hv_next;
        perf_reg <= perf_next;
    end

    // Both products are compared least significant bit first; only the
    // small running carry is kept, and its sign after the last bit gives the
    // sign of the full difference.
    always_comb
    begin
        a_term    = ap_reg[0] ? ecpm_pkg::ACTIVE_WEIGHT : '0;
        s86       = c86_reg + a_term - (mp_reg[0] ? ecpm_pkg::COMPUTE_WEIGHT : '0);
        s40       = c40_reg + a_term - (mp_reg[0] ? ecpm_pkg::MEMORY_WEIGHT : '0);
        ap_next   = ap_reg;
        mp_next   = mp_reg;
        c86_next  = c86_reg;
        c40_next  = c40_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        nz_next   = nz_reg;
        hv_next   = hv_reg;
        perf_next = perf_reg;
        if (load)
        begin
            ap_next   = active_cycles;
            mp_next   = reference_cycles;
            c86_next  = '0;
            c40_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            nz_next   = 1'b0;
            hv_next   = hint_valid;
            perf_next = hint_perf;
        end
        else if (busy_reg)
        begin
            ap_next  = {1'b0, ap_reg[ecpm_pkg::CYC_W-1:1]};
            mp_next  = {1'b0, mp_reg[ecpm_pkg::CYC_W-1:1]};
            c86_next = s86 >>> 1;
            c40_next = s40 >>> 1;
            nz_next  = nz_reg | mp_reg[0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ecpm_pkg::CLS_CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (!nz_reg)
        begin
            cls = ecpm_pkg::CLS_IDLE;
        end
        else if (hv_reg)
        begin
            if (perf_reg >= ecpm_pkg::PERF_COMPUTE)
            begin
                cls = ecpm_pkg::CLS_COMPUTE;
            end
            else if (perf_reg >= ecpm_pkg::PERF_MIXED)
            begin
                cls = ecpm_pkg::CLS_MIXED;
            end
            else
            begin
                cls = ecpm_pkg::CLS_MEMORY;
            end
        end
        else if (!c86_reg[ecpm_pkg::CARRY_W-1])
        begin
            cls = ecpm_pkg::CLS_COMPUTE;
        end
        else if (c40_reg[ecpm_pkg::CARRY_W-1])
        begin
            cls = ecpm_pkg::CLS_MEMORY;
        end
        else
        begin
            cls = ecpm_pkg::CLS_MIXED;
        end
    end

    assign status.done = !busy_reg;
    assign status.cls  = cls;

endmodule

// File: src/energy_counter_power_monitor.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                    Content
// s_*       in         s_tvalid / s_tready          one sample request
// m_*       out        m_tvalid / m_tready          one power result request
// APB       in         psel, penable, pwrite        energy unit exponent
//
// A result is worked out from its sample, for each counter, by two shift-and-add multiplies
// of one step per multiplier bit, each followed by a 52-step restoring division, in turn on
// one shared accumulator; the bit length of the energy unit sets the first multiply's steps.
// The priming sample goes straight to the done state and gives an all-zero result.
// Reset clears the stored counters, the primed flag and the exponent.
// A new sample is taken while a finished result still waits in the output
// register; the result of that sample waits until the output is free.

module energy_counter_power_monitor (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pkg_energy_count, dram_energy_count, elapsed time, active_cycles,
    // reference_cycles, hint_perf
    input  logic [247:0] s_tdata,
    // hint_valid
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // package power, DRAM power, core power, workload class
    output logic [55:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [ecpm_pkg::COUNT_W-1:0] pkg_now, dram_now;
    logic [ecpm_pkg::NS_W-1:0]    ns_in;

    ecpm_pkg::state_t state_reg, state_next;
    logic [ecpm_pkg::EXP_W-1:0]     exp_reg, exp_next;
    logic                           primed_reg, primed_next;
    logic [ecpm_pkg::COUNT_W-1:0]   last_pkg_reg, last_pkg_next;
    logic [ecpm_pkg::COUNT_W-1:0]   last_dram_reg, last_dram_next;
    logic [ecpm_pkg::COUNT_W-1:0]   dram_delta_reg, dram_delta_next;
    logic [ecpm_pkg::NS_W-1:0]      ns_reg, ns_next;
    logic [ecpm_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [ecpm_pkg::ACC_W-1:0]     mcand_reg, mcand_next;
    logic [ecpm_pkg::MPLIER_W-1:0]  mplier_reg, mplier_next;
    logic [ecpm_pkg::NS_W-1:0]      dvs_reg, dvs_next;
    logic [ecpm_pkg::NS_W-1:0]      rem_reg, rem_next;
    logic [ecpm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           chan_reg, chan_next;
    logic                           step_reg, step_next;
    logic                           zero_reg, zero_next;
    logic [ecpm_pkg::ACC_W-1:0]     pkg_q_reg, pkg_q_next;
    logic [ecpm_pkg::ACC_W-1:0]     dram_q_reg, dram_q_next;
    logic                           out_valid_reg, out_valid_next;
    logic [55:0]                    out_data_reg, out_data_next;

    logic [ecpm_pkg::UNIT_W-1:0]    unit_raw, unit;
    logic [ecpm_pkg::NS_W:0]        trial;
    logic                           q_bit;
    logic [ecpm_pkg::ACC_W-1:0]     quot, quot_fin;
    logic [ecpm_pkg::ACC_W-1:0]     core_raw, pkg_c, dram_c, core_c;
    logic                           accept, cfg_write, cls_load;
    ecpm_pkg::cls_status_t          cls_status;

    assign pkg_now  = s_tdata[31:0];
    assign dram_now = s_tdata[63:32];
    assign ns_in    = s_tdata[111:64];

    ecpm_classify u_classify (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (cls_load),
        .active_cycles    (s_tdata[175:112]),
        .reference_cycles (s_tdata[239:176]),
        .hint_valid       (s_tuser[0]),
        .hint_perf        (s_tdata[247:240]),
        .status           (cls_status)
    );

    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign exp_next  = cfg_write ? pwdata[ecpm_pkg::EXP_W-1:0] : exp_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {27'd0, exp_reg} : 32'd0;

    assign unit_raw = ecpm_pkg::MJ_PER_J >> exp_reg;
    assign unit     = (unit_raw == '0) ? 10'd1 : unit_raw;

    assign s_tready = (state_reg == ecpm_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cls_load = accept && primed_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign trial    = {rem_reg, acc_reg[ecpm_pkg::ACC_W-1]};
    assign q_bit    = (trial >= {1'b0, dvs_reg});
    assign quot     = {acc_reg[ecpm_pkg::ACC_W-2:0], q_bit};
    assign quot_fin = (ns_reg == '0) ? '0 : quot;

    always_comb
    begin
        core_raw = (pkg_q_reg > dram_q_reg) ? pkg_q_reg - dram_q_reg : '0;
        pkg_c    = (pkg_q_reg > ecpm_pkg::PKG_MAX_MW) ? ecpm_pkg::PKG_MAX_MW : pkg_q_reg;
        dram_c   = (dram_q_reg > ecpm_pkg::DRAM_MAX_MW) ? ecpm_pkg::DRAM_MAX_MW : dram_q_reg;
        core_c   = (core_raw > ecpm_pkg::CORE_MAX_MW) ? ecpm_pkg::CORE_MAX_MW : core_raw;
        if (core_c > pkg_c)
        begin
            core_c = pkg_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecpm_pkg::ST_IDLE;
            exp_reg       <= '0;
            primed_reg    <= 1'b0;
            last_pkg_reg  <= '0;
            last_dram_reg <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            chan_reg      <= 1'b0;
            step_reg      <= 1'b0;
            zero_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            primed_reg    <= primed_next;
            last_pkg_reg  <= last_pkg_next;
            last_dram_reg <= last_dram_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            chan_reg      <= chan_next;
            step_reg      <= step_next;
            zero_reg      <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dram_delta_reg <= dram_delta_next;
        ns_reg         <= ns_next;
        acc_reg        <= acc_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        dvs_reg        <= dvs_next;
        rem_reg        <= rem_next;
        pkg_q_reg      <= pkg_q_next;
        dram_q_reg     <= dram_q_next;
        out_data_reg   <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        primed_next     = primed_reg;
        last_pkg_next   = last_pkg_reg;
        last_dram_next  = last_dram_reg;
        dram_delta_next = dram_delta_reg;
        ns_next         = ns_reg;
        acc_next        = acc_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        dvs_next        = dvs_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        chan_next       = chan_reg;
        step_next       = step_reg;
        zero_next       = zero_reg;
        pkg_q_next      = pkg_q_reg;
        dram_q_next     = dram_q_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        unique case (state_reg)
            ecpm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    last_pkg_next  = pkg_now;
                    last_dram_next = dram_now;
                    primed_next    = 1'b1;
                    if (!primed_reg)
                    begin
                        zero_next  = 1'b1;
                        state_next = ecpm_pkg::ST_DONE;
                    end
                    else
                    begin
                        zero_next       = 1'b0;
                        ns_next         = ns_in;
                        dram_delta_next = dram_now - last_dram_reg;
                        mcand_next      = {20'd0, pkg_now - last_pkg_reg};
                        mplier_next     = {10'd0, unit};
                        acc_next        = '0;
                        chan_next       = 1'b0;
                        step_next       = 1'b0;
                        state_next      = ecpm_pkg::ST_MUL;
                    end
                end
            end
            ecpm_pkg::ST_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    dvs_next   = step_reg ? ns_reg : {38'd0, ecpm_pkg::MJ_PER_J};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ecpm_pkg::ST_DIV;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[ecpm_pkg::ACC_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[ecpm_pkg::MPLIER_W-1:1]};
                end
            end
            ecpm_pkg::ST_DIV:
            begin
                rem_next = q_bit ? (trial[ecpm_pkg::NS_W-1:0] - dvs_reg)
                                 : trial[ecpm_pkg::NS_W-1:0];
                acc_next = quot;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ecpm_pkg::DIV_LAST)
                begin
                    acc_next = '0;
                    if (!step_reg)
                    begin
                        mcand_next  = quot;
                        mplier_next = ecpm_pkg::NS_SCALE;
                        step_next   = 1'b1;
                        state_next  = ecpm_pkg::ST_MUL;
                    end
                    else if (!chan_reg)
                    begin
                        pkg_q_next  = quot_fin;
                        mcand_next  = {20'd0, dram_delta_reg};
                        mplier_next = {10'd0, unit};
                        chan_next   = 1'b1;
                        step_next   = 1'b0;
                        state_next  = ecpm_pkg::ST_MUL;
                    end
                    else
                    begin
                        dram_q_next = quot_fin;
                        state_next  = ecpm_pkg::ST_DONE;
                    end
                end
            end
            ecpm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    if (zero_reg)
                    begin
                        out_data_next = '0;
                    end
                    else
                    begin
                        out_data_next = {cls_status.cls,
                                         core_c[ecpm_pkg::CORE_MW_W-1:0],
                                         dram_c[ecpm_pkg::DRAM_MW_W-1:0],
                                         pkg_c[ecpm_pkg::PKG_MW_W-1:0]};
                    end
                    state_next = ecpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ecpm_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_core_below_pkg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[53:35] <= m_tdata[18:0]))
        else $error("core power above package power");

    a_pkg_dram_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[18:0] <= 19'd300000) && (m_tdata[34:19] <= 16'd50000)))
        else $error("power result beyond its clamp");

    a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second sample taken while one is at work");

    a_class_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ecpm_pkg::ST_DONE) && !zero_reg) |-> cls_status.done)
        else $error("class not settled when the result is formed");
`endif

endmodule

// File: tb/tb_energy_counter_power_monitor.sv
`timescale 1ns / 1ps

module tb_energy_counter_power_monitor;

    typedef struct {
        logic [31:0] pkg_cnt;
        logic [31:0] dram_cnt;
        logic [47:0] ns;
        logic [63:0] act;
        logic [63:0] refc;
        logic        hv;
        logic [7:0]  perf;
    } sample_t;

    typedef struct {
        logic [18:0]      pkg_mw;
        logic [15:0]      dram_mw;
        logic [18:0]      core_mw;
        ecpm_pkg::class_t cls;
    } power_t;

    class power_scoreboard;
        logic [4:0]  exponent;
        logic [31:0] last_pkg;
        logic [31:0] last_dram;
        bit          primed;
        power_t      pending[$];
        int          errors;
        int          checked;

        function void clear();
            exponent = '0;
            last_pkg = '0;
            last_dram = '0;
            primed = 0;
            pending.delete();
            errors = 0;
            checked = 0;
        endfunction

        function logic [127:0] to_mw(logic [31:0] delta, logic [47:0] ns);
            logic [127:0] unit;
            logic [127:0] mj;
            unit = 128'd1000 >> exponent;
            if (unit == 0)
                unit = 1;
            if (ns == 0)
                return 0;
            mj = (128'(delta) * unit) / 1000;
            return (mj * 1000000) / 128'(ns);
        endfunction

        function ecpm_pkg::class_t classify(sample_t s);
            logic [127:0] a;
            logic [127:0] r;
            if (s.refc == 0)
                return ecpm_pkg::CLS_IDLE;
            if (s.hv)
            begin
                if (s.perf >= 200)
                    return ecpm_pkg::CLS_COMPUTE;
                if (s.perf >= 100)
                    return ecpm_pkg::CLS_MIXED;
                return ecpm_pkg::CLS_MEMORY;
            end
            a = 128'(s.act) * 100;
            r = 128'(s.refc);
            if (a >= r * 86)
                return ecpm_pkg::CLS_COMPUTE;
            if (a < r * 40)
                return ecpm_pkg::CLS_MEMORY;
            return ecpm_pkg::CLS_MIXED;
        endfunction

        function void note_sample(sample_t s);
            power_t p;
            logic [127:0] pk;
            logic [127:0] dr;
            logic [127:0] co;
            if (!primed)
            begin
                p.pkg_mw = 0;
                p.dram_mw = 0;
                p.core_mw = 0;
                p.cls = ecpm_pkg::CLS_IDLE;
                primed = 1;
            end
            else
            begin
                pk = to_mw(s.pkg_cnt - last_pkg, s.ns);
                dr = to_mw(s.dram_cnt - last_dram, s.ns);
                co = (pk > dr) ? pk - dr : 0;
                if (pk > 300000)
                    pk = 300000;
                if (dr > 50000)
                    dr = 50000;
                if (co > 280000)
                    co = 280000;
                if (co > pk)
                    co = pk;
                p.pkg_mw = pk[18:0];
                p.dram_mw = dr[15:0];
                p.core_mw = co[18:0];
                p.cls = classify(s);
            end
            last_pkg = s.pkg_cnt;
            last_dram = s.dram_cnt;
            pending.push_back(p);
        endfunction

        function void check_result(logic [55:0] d);
            power_t e;
            if (pending.size() == 0)
            begin
                $error("result with no sample outstanding: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (d[18:0] !== e.pkg_mw)
            begin
                $error("package power expected %0d actual %0d", e.pkg_mw, d[18:0]);
                errors++;
            end
            if (d[34:19] !== e.dram_mw)
            begin
                $error("DRAM power expected %0d actual %0d", e.dram_mw, d[34:19]);
                errors++;
            end
            if (d[53:35] !== e.core_mw)
            begin
                $error("core_power_mw expected %0d actual %0d", e.core_mw, d[53:35]);
                errors++;
            end
            if (d[55:54] !== e.cls)
            begin
                $error("workload_class expected %0d actual %0d", e.cls, d[55:54]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [247:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    power_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  cycle_count;
    int  sent;

    energy_counter_power_monitor u_top (.*);

    initial
    begin
        clk = 0;
    end

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2500000)
        begin
            $display("energy_counter_power_monitor regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_sample(sample_t'{s_tdata[31:0], s_tdata[63:32], s_tdata[111:64],
                    s_tdata[175:112], s_tdata[239:176], s_tuser[0], s_tdata[247:240]});
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_sample(sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {s.perf, s.refc, s.act, s.ns, s.dram_cnt, s.pkg_cnt};
        s_tuser <= s.hv;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic write_exponent(logic [4:0] value);
        int n;
        n = 0;
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        while (n < 400)
        begin
            @(posedge clk);
            n++;
        end
        psel <= 1;
        pwrite <= 1;
        paddr <= '0;
        pwdata <= {$urandom} & ~32'h1f | value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.exponent = value;
    endtask

    function automatic sample_t random_sample(sample_t prev);
        sample_t s;
        int k;
        k = $urandom_range(9);
        s.pkg_cnt = (k < 6) ? prev.pkg_cnt + ($urandom >> $urandom_range(31)) : $urandom;
        s.dram_cnt = (k < 6) ? prev.dram_cnt + ($urandom >> $urandom_range(31)) : $urandom;
        case ($urandom_range(5))
            0: s.ns = 0;
            1: s.ns = 48'({$urandom, $urandom});
            2: s.ns = 48'hffff_ffff_ffff;
            default: s.ns = 48'($urandom >> $urandom_range(31));
        endcase
        s.refc = {$urandom, $urandom} >> $urandom_range(63);
        case ($urandom_range(3))
            0: s.act = {$urandom, $urandom};
            1: s.act = s.refc;
            2: s.act = (s.refc * $urandom_range(120)) / 100;
            default: s.act = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        if ($urandom_range(7) == 0)
            s.refc = 0;
        s.hv = 1'($urandom_range(1));
        s.perf = 8'($urandom);
        return s;
    endfunction

    sample_t cur;

    initial
    begin
        sb = new();
        sb.clear();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        cycle_count = 0;
        sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        cur = sample_t'{32'hffff_fff0, 32'h10, 48'd1000, 64'd0, 64'd0, 1'b0, 8'd0};
        send_sample(cur);
        cur = sample_t'{32'h5, 32'hffff_ffff, 48'd1000, 64'd90, 64'd100, 1'b0, 8'd0};
        send_sample(cur);
        cur = sample_t'{32'h100, 32'h100, 48'd0, 64'd86, 64'd100, 1'b0, 8'd0};
        send_sample(cur);
        cur = sample_t'{32'h200, 32'h180, 48'd1, 64'd85, 64'd100, 1'b0, 8'd0};
        send_sample(cur);
        cur = sample_t'{32'h300, 32'h181, 48'd1000000, 64'd40, 64'd100, 1'b0, 8'd0};
        send_sample(cur);
        cur = sample_t'{32'h300, 32'h181, 48'hffff_ffff_ffff, 64'd39, 64'd100, 1'b0, 8'd0};
        send_sample(cur);
        cur = sample_t'{32'h0, 32'h0, 48'd777, {64{1'b1}}, {64{1'b1}}, 1'b1, 8'd200};
        send_sample(cur);
        cur = sample_t'{32'h10, 32'h10, 48'd777, 64'd0, 64'd5, 1'b1, 8'd199};
        send_sample(cur);
        cur = sample_t'{32'h20, 32'h30, 48'd777, 64'd0, 64'd5, 1'b1, 8'd100};
        send_sample(cur);
        cur = sample_t'{32'h30, 32'h40, 48'd777, {64{1'b1}}, 64'd1, 1'b1, 8'd99};
        send_sample(cur);
        cur = sample_t'{32'h40, 32'h50, 48'd777, 64'd5, 64'd0, 1'b1, 8'd255};
        send_sample(cur);
        write_exponent(5'd31);
        cur = sample_t'{32'hffff_ffff, 32'hffff_ffff, 48'd3, 64'd1, 64'd3, 1'b0, 8'd0};
        send_sample(cur);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_exponent((ph == 5) ? 5'd0 : 5'($urandom_range(31)));
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 75; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 75; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                hold_off = 1;
                fork
                    begin
                        repeat (3000) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int i = 0; i < 123; i++)
            begin
                cur = random_sample(cur);
                send_sample(cur);
            end
        end

        s_tvalid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Sent %0d samples over six exponent settings and four idling patterns;",
            sent);
        $display("%0d power results compared field by field.", sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("energy_counter_power_monitor regression: pass");
        else
            $display("energy_counter_power_monitor regression: fail");
        $finish;
    end

endmodule
